FILE: design/qte_pkg.sv
package qte_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CORDIC_CELLS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int SQRT_CELLS   = 29;
   localparam int FRONT_STAGES = 4;
   localparam int VALID_STAGES = FRONT_STAGES + SQRT_CELLS + 1 + CORDIC_CELLS;

   localparam int SW = 35;   // sin/cos terms, Q.28
   localparam int VW = 37;   // cordic x/y
   localparam int ZW = 26;   // angle, degrees Q.16
   localparam int NW = 58;   // square root operands
   localparam int PW = 29;   // pitch sine, non-gimbal range

   localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
   localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
   localparam logic signed [15:0] PITCH_LIM = 16'sd11520;
   localparam logic signed [15:0] ANGLE_LIM = 16'sd23040;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 done;
   } cordic_type;

   typedef struct packed {
      logic [NW-1:0] n;
      logic [NW-1:0] r;
   } sqrt_type;

   typedef struct packed {
      logic signed [SW-1:0] sin_y;
      logic signed [SW-1:0] cos_y;
      logic signed [SW-1:0] sin_r;
      logic signed [SW-1:0] cos_r;
      logic signed [PW-1:0] sin_p;
      logic                 gimbal;
      logic                 gsign;
   } side_type;

   function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
      logic signed [ZW-1:0] a;
      unique case (i)
         5'd0:  a = ZW'(2949120);
         5'd1:  a = ZW'(1740967);
         5'd2:  a = ZW'(919879);
         5'd3:  a = ZW'(466945);
         5'd4:  a = ZW'(234379);
         5'd5:  a = ZW'(117304);
         5'd6:  a = ZW'(58666);
         5'd7:  a = ZW'(29335);
         5'd8:  a = ZW'(14668);
         5'd9:  a = ZW'(7334);
         5'd10: a = ZW'(3667);
         5'd11: a = ZW'(1833);
         5'd12: a = ZW'(917);
         5'd13: a = ZW'(458);
         5'd14: a = ZW'(229);
         5'd15: a = ZW'(115);
         5'd16: a = ZW'(57);
         5'd17: a = ZW'(29);
         5'd18: a = ZW'(14);
         5'd19: a = ZW'(7);
         5'd20: a = ZW'(4);
         5'd21: a = ZW'(2);
         5'd22: a = ZW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

   // axis cases resolve here; left half-plane turned by 180
   function automatic cordic_type cordic_prep(input logic signed [VW-1:0] y,
                                              input logic signed [VW-1:0] x);
      cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      c.done = 1'b0;
      if (y == '0) begin
         c.done = 1'b1;
         c.z = (x < 0) ? DEG180 : '0;
      end else if (x == '0) begin
         c.done = 1'b1;
         c.z = (y > 0) ? DEG90 : -DEG90;
      end else if (x < 0) begin
         c.z = (y >= 0) ? DEG180 : -DEG180;
         c.x = -x;
         c.y = -y;
      end
      return c;
   endfunction

   function automatic logic signed [15:0] to_q97(input logic signed [ZW-1:0] z,
                                                 input logic signed [15:0] lim);
      logic signed [ZW:0]   t;
      logic signed [ZW-9:0] r;
      logic signed [ZW-9:0] l;
      t = (ZW+1)'(z) + (ZW+1)'(256);
      r = (ZW-8)'(t >>> 9);
      l = (ZW-8)'(lim);
      if (r > l) r = l;
      if (r < -l) r = -l;
      return 16'(r);
   endfunction

endpackage

FILE: design/qte_sqrt_cell.sv
module qte_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  logic [4:0]         idx,
   input  qte_pkg::sqrt_type  s_in,
   input  qte_pkg::side_type  side_in,
   output qte_pkg::sqrt_type  s_ff,
   output qte_pkg::side_type  side_ff
);

   logic [qte_pkg::NW-1:0] bit_w;
   logic [qte_pkg::NW-1:0] t;
   qte_pkg::sqrt_type      s_in_nx;

   always_comb begin
      bit_w = qte_pkg::NW'(1) << (6'd56 - {idx, 1'b0});
      t = s_in.r + bit_w;
      if (s_in.n >= t) begin
         s_in_nx.n = s_in.n - t;
         s_in_nx.r = (s_in.r >> 1) + bit_w;
      end else begin
         s_in_nx.n = s_in.n;
         s_in_nx.r = s_in.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in_nx;
         side_ff <= side_in;
      end
   end

endmodule

FILE: design/qte_cordic_cell.sv
module qte_cordic_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          idx,
   input  qte_pkg::cordic_type c_in,
   output qte_pkg::cordic_type c_ff
);

   logic signed [qte_pkg::VW-1:0] xs;
   logic signed [qte_pkg::VW-1:0] ys;
   qte_pkg::cordic_type           c_in_nx;

   always_comb begin
      xs = c_in.x >>> idx;
      ys = c_in.y >>> idx;
      c_in_nx = c_in;
      if (!c_in.done) begin
         if (c_in.y >= 0) begin
            c_in_nx.x = c_in.x + ys;
            c_in_nx.y = c_in.y - xs;
            c_in_nx.z = c_in.z + qte_pkg::atan_deg(idx);
         end else begin
            c_in_nx.x = c_in.x - ys;
            c_in_nx.y = c_in.y + xs;
            c_in_nx.z = c_in.z - qte_pkg::atan_deg(idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) c_ff <= c_in_nx;
   end

endmodule

FILE: design/quaternion_to_euler_angles_unit.sv
// Z-Y-X Euler angles from a Q2.14 quaternion, in Q9.7 degrees. Fully pipelined:
// one beat per cycle in and out (4 product and square stages, a 29-cell square
// root row, one prep stage, one CORDIC cell per step, one output register). The
// whole pipe stalls only while a result beat is held at the output.
// gimbal_clamped marks pitch saturated to +-90.
module quaternion_to_euler_angles_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // pitch_deg, yaw_deg, roll_deg, gimbal_clamped
);

   localparam int SW = qte_pkg::SW;
   localparam int NE = qte_pkg::CORDIC_CELLS;
   localparam int NS = qte_pkg::SQRT_CELLS;
   localparam int VL = qte_pkg::VALID_STAGES;
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< 28;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic [VL-1:0] vld_ff;
   logic          rsp_tvalid_ff;
   logic [47:0]   rsp_tdata_ff;
   logic [47:0]   rsp_tdata_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[VL-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[VL-1];
      end
   end

   // stage 1: products
   logic signed [15:0] qw, qx, qy, qz;
   assign qw = $signed(req_tdata[15:0]);
   assign qx = $signed(req_tdata[31:16]);
   assign qy = $signed(req_tdata[47:32]);
   assign qz = $signed(req_tdata[63:48]);

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= qw * qx;
         yz_ff <= qy * qz;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         wy_ff <= qw * qy;
         zx_ff <= qz * qx;
         wz_ff <= qw * qz;
         xy_ff <= qx * qy;
         zz_ff <= qz * qz;
      end
   end

   // stage 2: sine and cosine terms
   logic signed [SW-1:0] sin_p_in;
   logic [27:0]          s_abs_ff, s_abs_in;
   qte_pkg::side_type    side2_ff, side2_in;

   always_comb begin
      side2_in.sin_r = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      side2_in.cos_r = ONE - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
      side2_in.sin_y = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
      side2_in.cos_y = ONE - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      sin_p_in = (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
      side2_in.sin_p = qte_pkg::PW'(sin_p_in);
      side2_in.gimbal = (sin_p_in >= ONE) || (sin_p_in <= -ONE);
      side2_in.gsign = sin_p_in[SW-1];
      s_abs_in = sin_p_in[SW-1] ? 28'(-sin_p_in) : 28'(sin_p_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side2_in;
         s_abs_ff <= s_abs_in;
      end
   end

   // stage 3: partial squares of |sin_p|
   logic [27:0]       aa_ff, ab_ff, bb_ff;
   qte_pkg::side_type side3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         aa_ff    <= s_abs_ff[27:14] * s_abs_ff[27:14];
         ab_ff    <= s_abs_ff[27:14] * s_abs_ff[13:0];
         bb_ff    <= s_abs_ff[13:0] * s_abs_ff[13:0];
         side3_ff <= side2_ff;
      end
   end

   // stage 4: radicand 1 - s*s
   qte_pkg::sqrt_type sq_ff, sq_in;
   qte_pkg::side_type side4_ff;
   always_comb begin
      sq_in.n = (qte_pkg::NW'(1) << 56)
              - ((qte_pkg::NW'(aa_ff) << 28) + (qte_pkg::NW'(ab_ff) << 15)
                 + qte_pkg::NW'(bb_ff));
      sq_in.r = '0;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         side4_ff <= side3_ff;
      end
   end

   // square root row
   qte_pkg::sqrt_type sq_c [NS+1];
   qte_pkg::side_type sd_c [NS+1];
   assign sq_c[0] = sq_ff;
   assign sd_c[0] = side4_ff;

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock   (clock),
         .en      (en),
         .idx     (5'(k)),
         .s_in    (sq_c[k]),
         .side_in (sd_c[k]),
         .s_ff    (sq_c[k+1]),
         .side_ff (sd_c[k+1])
      );
   end

   // prep stage and three CORDIC rows
   qte_pkg::cordic_type pc [NE+1];
   qte_pkg::cordic_type yc [NE+1];
   qte_pkg::cordic_type rc [NE+1];
   logic [1:0]          g_ff [NE+1];

   always_ff @(posedge clock) begin
      if (en) begin
         pc[0] <= qte_pkg::cordic_prep(qte_pkg::VW'(sd_c[NS].sin_p),
                                       $signed(sq_c[NS].r[qte_pkg::VW-1:0]));
         yc[0] <= qte_pkg::cordic_prep(qte_pkg::VW'(sd_c[NS].sin_y),
                                       qte_pkg::VW'(sd_c[NS].cos_y));
         rc[0] <= qte_pkg::cordic_prep(qte_pkg::VW'(sd_c[NS].sin_r),
                                       qte_pkg::VW'(sd_c[NS].cos_r));
         g_ff[0] <= {sd_c[NS].gsign, sd_c[NS].gimbal};
      end
   end

   for (genvar k = 0; k < NE; k++) begin : g_cordic
      qte_cordic_cell u_p (.clock(clock), .en(en), .idx(5'(k)), .c_in(pc[k]), .c_ff(pc[k+1]));
      qte_cordic_cell u_y (.clock(clock), .en(en), .idx(5'(k)), .c_in(yc[k]), .c_ff(yc[k+1]));
      qte_cordic_cell u_r (.clock(clock), .en(en), .idx(5'(k)), .c_in(rc[k]), .c_ff(rc[k+1]));
      always_ff @(posedge clock) begin
         if (en) g_ff[k+1] <= g_ff[k];
      end
   end

   // output register
   logic signed [15:0] pitch_w, yaw_w, roll_w;
   always_comb begin
      if (g_ff[NE][0])
         pitch_w = g_ff[NE][1] ? -qte_pkg::PITCH_LIM : qte_pkg::PITCH_LIM;
      else
         pitch_w = qte_pkg::to_q97(pc[NE].z, qte_pkg::PITCH_LIM);
      yaw_w  = qte_pkg::to_q97(yc[NE].z, qte_pkg::ANGLE_LIM);
      roll_w = qte_pkg::to_q97(rc[NE].z, qte_pkg::ANGLE_LIM);
      rsp_tdata_in = {g_ff[NE][0], roll_w, yaw_w, pitch_w[14:0]};
   end

   always_ff @(posedge clock) begin
      if (en) rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;

   localparam longint ONE_Q28  = 64'sd1 <<< 28;
   localparam longint D90_Q16  = 64'sd90 <<< 16;
   localparam longint D180_Q16 = 64'sd180 <<< 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // quat_w, quat_x, quat_y, quat_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // pitch_deg, yaw_deg, roll_deg, gimbal_clamped

   logic [47:0] angles_due[$];
   int          errors;
   int          quats_sent;
   int          angles_seen;
   int          gimbal_seen;
   int          idle_cycles;
   int          rsp_hold;
   bit          no_gaps;
   bit          finished;

   quaternion_to_euler_angles_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint atan_step_q16(int i);
      longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
      return steps[i];
   endfunction

   function automatic longint floor_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint vector_angle_q16(longint yv, longint xv);
      longint a;
      longint xs;
      longint ys;
      a = 0;
      if (yv == 0) return (xv < 0) ? D180_Q16 : 0;
      if (xv == 0) return (yv > 0) ? D90_Q16 : -D90_Q16;
      if (xv < 0) begin
         a = (yv >= 0) ? D180_Q16 : -D180_Q16;
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (yv >= 0) begin
            xv = xv + ys;
            yv = yv - xs;
            a = a + atan_step_q16(i);
         end else begin
            xv = xv - ys;
            yv = yv + xs;
            a = a - atan_step_q16(i);
         end
      end
      return a;
   endfunction

   function automatic longint deg_q97(longint a, longint lim);
      longint r;
      r = (a + 256) >>> 9;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic logic [47:0] euler_from_quat(logic [63:0] q);
      longint w, x, y, z;
      longint sin_r, cos_r, sin_p, sin_y, cos_y;
      longint pitch, yaw, roll;
      logic   clamp;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      sin_r = 2 * (w * x + y * z);
      cos_r = ONE_Q28 - 2 * (x * x + y * y);
      sin_p = 2 * (w * y - z * x);
      sin_y = 2 * (w * z + x * y);
      cos_y = ONE_Q28 - 2 * (y * y + z * z);
      clamp = 1'b0;
      if (sin_p >= ONE_Q28) begin
         pitch = 11520;
         clamp = 1'b1;
      end else if (sin_p <= -ONE_Q28) begin
         pitch = -11520;
         clamp = 1'b1;
      end else begin
         pitch = deg_q97(vector_angle_q16(sin_p,
                    floor_sqrt((64'd1 << 56) - longint'(sin_p * sin_p))), 11520);
      end
      yaw  = deg_q97(vector_angle_q16(sin_y, cos_y), 23040);
      roll = deg_q97(vector_angle_q16(sin_r, cos_r), 23040);
      return {clamp, roll[15:0], yaw[15:0], pitch[14:0]};
   endfunction

   function automatic int pick_gap();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x, w};
      do @(posedge clock); while (!req_tready);
      angles_due.push_back(euler_from_quat({z, y, x, w}));
      quats_sent++;
   endtask

   // Q2.14 component with magnitude up to 1.0
   function automatic logic signed [15:0] unit_comp();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic test_directed();
      send_quat(16384, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(0, -16384, 0, 0);
      send_quat(11585, 0, 11585, 0);
      send_quat(11586, 0, 11586, 0);
      send_quat(11586, 0, -11586, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(0, 11586, 0, 11586);
      send_quat(16384, 0, 0, -16);
      send_quat(16384, 16, 0, 0);
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(-32768, 32767, 0, 32767);
      send_quat(8192, 8192, 8192, 8192);
      send_quat(1, -1, 1, -1);
      send_quat(-1, 1, -1, 1);
      send_quat(-16384, 16384, -16384, 16384);
   endtask

   task automatic test_unit_range(int n);
      for (int i = 0; i < n; i++)
         send_quat(unit_comp(), unit_comp(), unit_comp(), unit_comp());
   endtask

   task automatic test_near_gimbal(int n);
      logic signed [15:0] a;
      logic signed [15:0] b;
      for (int i = 0; i < n; i++) begin
         a = 16'($urandom_range(11570, 11600));
         b = 16'($signed($urandom_range(0, 40)) - 20);
         case ($urandom_range(0, 3))
            0: send_quat(a, b, a, b);
            1: send_quat(a, b, -a, -b);
            2: send_quat(b, -a, b, a);
            default: send_quat(-a, b, -a, unit_comp() >>> 8);
         endcase
      end
   endtask

   task automatic test_raw_patterns(int n);
      for (int i = 0; i < n; i++)
         send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic test_back_to_back(int n);
      no_gaps = 1'b1;
      test_unit_range(n);
      no_gaps = 1'b0;
   endtask

   // mostly short stalls on the result side, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         automatic int p = $urandom_range(0, 99);
         rsp_tready <= (p < 70) ? 1'b1 : 1'b0;
         if (p >= 98) rsp_hold <= $urandom_range(10, 40);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         angles_seen++;
         if (angles_due.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            automatic logic [47:0] e = angles_due.pop_front();
            if (e[47]) gimbal_seen++;
            if (e[14:0] !== rsp_tdata[14:0]) begin
               $display("%0t: pitch expected %0d actual %0d", $time,
                        $signed(e[14:0]), $signed(rsp_tdata[14:0]));
               errors++;
            end
            if (e[30:15] !== rsp_tdata[30:15]) begin
               $display("%0t: yaw expected %0d actual %0d", $time,
                        $signed(e[30:15]), $signed(rsp_tdata[30:15]));
               errors++;
            end
            if (e[46:31] !== rsp_tdata[46:31]) begin
               $display("%0t: roll expected %0d actual %0d", $time,
                        $signed(e[46:31]), $signed(rsp_tdata[46:31]));
               errors++;
            end
            if (e[47] !== rsp_tdata[47]) begin
               $display("%0t: gimbal expected %0b actual %0b", $time, e[47], rsp_tdata[47]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || finished || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, %0d results outstanding", $time, angles_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      errors      = 0;
      quats_sent  = 0;
      angles_seen = 0;
      gimbal_seen = 0;
      idle_cycles = 0;
      no_gaps     = 1'b0;
      finished    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_unit_range(800);
      test_near_gimbal(200);
      test_back_to_back(250);
      test_raw_patterns(500);
      req_tvalid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      finished = 1'b1;
      $display("sent %0d quaternions, checked %0d results (%0d gimbal), %0d mismatches",
               quats_sent, angles_seen, gimbal_seen, errors);
      $display("covered axes, gimbal edges, unit range, raw 16-bit patterns, stalls");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: quaternion_to_euler_angles_unit.f
design/qte_pkg.sv
design/qte_sqrt_cell.sv
design/qte_cordic_cell.sv
design/quaternion_to_euler_angles_unit.sv
bench/tb.sv
